FILE: hw/rtl/rmt_pkg.sv
package rmt_pkg;

   // Request kinds carried in req_tuser.
   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Value of every table entry after reset and the answer to an empty range.
   localparam logic signed [61:0] SENTINEL = 62'sd2000000000000000000;

   // Largest positive 62-bit value; seeds the running minimum.
   localparam logic signed [61:0] MAX_VALUE = {1'b0, {61{1'b1}}};

   // Size register value after reset.
   localparam logic [12:0] SIZE_RESET = 13'd4096;

   typedef struct packed {
      logic                req_type;
      logic [11:0]         position;
      logic signed [61:0]  value;
      logic [12:0]         range_start;
      logic [12:0]         range_end;
   } item_type;

   typedef struct packed {
      logic signed [61:0]  minimum;
      logic                empty_range;
   } result_type;

endpackage

FILE: hw/rtl/rmt_ram.sv
module rmt_ram #(
   parameter int WIDTH = 62,
   parameter int WORDS = 20480
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(WORDS)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(WORDS)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [WORDS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/rmt_engine.sv
module rmt_engine #(
   parameter int DEPTH  = 4096,
   parameter int LEVELS = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  rmt_pkg::item_type    item,
   input  logic [12:0]          size,
   output logic                 ready,
   output logic                 res_valid,
   output rmt_pkg::result_type  res,
   input  logic                 res_ready
);

   localparam int WORDS = LEVELS * DEPTH;
   localparam int RAW   = $clog2(WORDS);
   localparam int MW    = (3 * LEVELS > RAW) ? 3 * LEVELS : RAW;
   localparam int CW    = ((MW > 14) ? MW : 14) + 2;
   localparam int LW    = $clog2(LEVELS + 1);

   localparam logic [2:0] S_CLEAR     = 3'd0;
   localparam logic [2:0] S_IDLE      = 3'd1;
   localparam logic [2:0] S_ADD_CHECK = 3'd2;
   localparam logic [2:0] S_ADD_READ  = 3'd3;
   localparam logic [2:0] S_ADD_WAIT  = 3'd4;
   localparam logic [2:0] S_Q_STEP    = 3'd5;
   localparam logic [2:0] S_DONE      = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [RAW-1:0]      clr_ff, clr_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [LW-1:0]       lvl_ff, lvl_in;
   logic [CW-1:0]       lvl_off_ff, lvl_off_in;
   logic [CW-1:0]       blk_ff, blk_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [CW-1:0]       ptr_ff, ptr_in;
   logic [CW-1:0]       a_ff, a_in;
   logic signed [61:0]  acc_ff, acc_in;
   logic                rd_valid_ff, rd_oob_ff;
   rmt_pkg::result_type res_ff, res_in;

   logic                wr_en, rd_en, rd_issue, rd_oob;
   logic [CW-1:0]       wr_addr_w, rd_addr_w;
   logic signed [61:0]  wr_data, rd_data, rd_val, acc_next;
   logic [CW-1:0]       size_w, size_eff, pos_w, a_w, b_w, len, q_blk, q_off, step_ptr;
   logic [LW-1:0]       q_lvl;

   rmt_ram #(.WIDTH(62), .WORDS(WORDS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr_w[RAW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_w[RAW-1:0]),
      .rd_data (rd_data)
   );

   // Positions outside the table read as the sentinel.
   assign rd_val   = rd_oob_ff ? rmt_pkg::SENTINEL : rd_data;
   assign acc_next = (rd_valid_ff && (rd_val < acc_ff)) ? rd_val : acc_ff;
   assign rd_en    = rd_issue && !rd_oob;

   assign size_w   = CW'(size);
   assign size_eff = (size_w > CW'(DEPTH)) ? CW'(DEPTH) : size_w;
   assign pos_w    = CW'(item.position);
   assign a_w      = CW'(item.range_start);
   assign b_w      = CW'(item.range_end);
   assign len      = b_w - a_w;
   assign step_ptr = ptr_ff - blk_ff;

   // Largest level whose block fits in the range, capped at the top level.
   always_comb begin
      q_lvl = '0;
      for (int j = 1; j < LEVELS; j++) begin
         if (len >= (CW'(1) << (3 * j))) begin
            q_lvl = LW'(j);
         end
      end
   end

   assign q_blk = CW'(1) << (3 * q_lvl);
   assign q_off = CW'(q_lvl) * CW'(DEPTH);

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      pos_in     = pos_ff;
      lvl_in     = lvl_ff;
      lvl_off_in = lvl_off_ff;
      blk_in     = blk_ff;
      cnt_in     = cnt_ff;
      ptr_in     = ptr_ff;
      a_in       = a_ff;
      acc_in     = acc_ff;
      res_in     = res_ff;
      wr_en      = 1'b0;
      wr_addr_w  = '0;
      wr_data    = rmt_pkg::SENTINEL;
      rd_issue   = 1'b0;
      rd_oob     = 1'b0;
      rd_addr_w  = '0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en     = 1'b1;
            wr_addr_w = CW'(clr_ff);
            clr_in    = clr_ff + RAW'(1);
            if (clr_ff == RAW'(WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               if (item.req_type == rmt_pkg::REQ_ADD) begin
                  // An add outside the table is dropped.
                  if (pos_w < CW'(DEPTH)) begin
                     wr_en      = 1'b1;
                     wr_addr_w  = pos_w;
                     wr_data    = item.value;
                     pos_in     = pos_w;
                     lvl_in     = LW'(1);
                     lvl_off_in = CW'(DEPTH);
                     blk_in     = CW'(8);
                     state_in   = S_ADD_CHECK;
                  end
               end else if (a_w >= b_w) begin
                  res_in   = '{minimum: rmt_pkg::SENTINEL, empty_range: 1'b1};
                  state_in = S_DONE;
               end else begin
                  rd_issue   = 1'b1;
                  rd_oob     = a_w >= CW'(DEPTH);
                  rd_addr_w  = q_off + a_w;
                  acc_in     = rmt_pkg::MAX_VALUE;
                  a_in       = a_w;
                  ptr_in     = b_w;
                  blk_in     = q_blk;
                  lvl_off_in = q_off;
                  state_in   = S_Q_STEP;
               end
            end
         end
         S_ADD_CHECK: begin
            if ((lvl_ff == LW'(LEVELS)) || ((pos_ff + blk_ff) > size_eff)) begin
               state_in = S_IDLE;
            end else begin
               // Old value of the entry first, then its eight children.
               rd_issue  = 1'b1;
               rd_addr_w = lvl_off_ff + pos_ff;
               ptr_in    = pos_ff;
               cnt_in    = '0;
               acc_in    = rmt_pkg::MAX_VALUE;
               state_in  = S_ADD_READ;
            end
         end
         S_ADD_READ: begin
            rd_issue  = 1'b1;
            rd_addr_w = lvl_off_ff - CW'(DEPTH) + ptr_ff;
            ptr_in    = ptr_ff + (blk_ff >> 3);
            acc_in    = acc_next;
            cnt_in    = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               state_in = S_ADD_WAIT;
            end
         end
         S_ADD_WAIT: begin
            wr_en      = 1'b1;
            wr_addr_w  = lvl_off_ff + pos_ff;
            wr_data    = acc_next;
            lvl_in     = lvl_ff + LW'(1);
            lvl_off_in = lvl_off_ff + CW'(DEPTH);
            blk_in     = blk_ff << 3;
            state_in   = S_ADD_CHECK;
         end
         S_Q_STEP: begin
            acc_in = acc_next;
            if (ptr_ff >= (a_ff + blk_ff)) begin
               rd_issue  = 1'b1;
               rd_oob    = step_ptr >= CW'(DEPTH);
               rd_addr_w = lvl_off_ff + step_ptr;
               ptr_in    = step_ptr;
            end else begin
               res_in   = '{minimum: acc_next, empty_range: 1'b0};
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ff      <= '0;
         rd_valid_ff <= 1'b0;
         rd_oob_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         rd_valid_ff <= rd_issue;
         rd_oob_ff   <= rd_oob;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      lvl_ff     <= lvl_in;
      lvl_off_ff <= lvl_off_in;
      blk_ff     <= blk_in;
      cnt_ff     <= cnt_in;
      ptr_ff     <= ptr_in;
      a_ff       <= a_in;
      acc_ff     <= acc_in;
      res_ff     <= res_in;
   end

   assign ready     = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   // The table port is used for one access a cycle.
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("table read and write in the same cycle");

   // Child reads of an add arrive back to back behind the first read.
   a_add_pipe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD_READ) |-> rd_valid_ff)
      else $error("add fold lost its read data");

   // A pending result holds until it is taken.
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_ready) |=> (res_valid && $stable(res)))
      else $error("result changed while stalled");

   // An empty range always answers with the sentinel.
   a_empty_sentinel: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.empty_range) |-> (res.minimum == rmt_pkg::SENTINEL))
      else $error("empty range without sentinel");

   // No item is taken while the table is being cleared.
   a_no_start_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !ready)
      else $error("ready during clearing pass");

endmodule

FILE: hw/rtl/radix8_range_min_table.sv
// Radix-8 range-minimum table. An add item (req_tuser = 0) stores a signed
// 62-bit value at a position of level 0 and then folds it into every higher
// level k whose block of 8^k positions still fits below the size register;
// positions are meant to arrive in descending order. A query item
// (req_tuser = 1) returns the minimum over [range_start, range_end) on the
// response channel, or 2e18 with the empty flag when start is not below end.
// All levels live in one synchronous RAM of LEVELS * DEPTH entries with a
// write port and a read port, and the engine works on one item at a time.
// An add visits each of the L upper levels it updates in turn, with a RAM
// read of the old entry and of its eight children and then a write-back.
// A query reads the block at the range start and then n = floor(length /
// 8^k) blocks stepping down from the range end (at most seven below the
// top level). After reset the engine sweeps the RAM to the sentinel, one
// entry a cycle, over all LEVELS * DEPTH entries (20480 by default) and
// accepts no item meanwhile; writes to the size register are taken at any
// time. A finished result sits in the output register, so the next item
// is accepted while it waits.
module radix8_range_min_table #(
   parameter int DEPTH  = 4096,
   parameter int LEVELS = 5
) (
   input  logic         clock,
   input  logic         reset,

   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // req_tdata: position[11:0], value[73:12], range_start[86:74],
   // range_end[99:87], zero fill[103:100].
   input  logic [103:0] req_tdata,
   // req_tuser: req_type[0] (0 = add, 1 = query).
   input  logic [0:0]   req_tuser,

   // Response channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rsp_tdata: minimum[61:0], zero fill[63:62].
   output logic [63:0]  rsp_tdata,
   // rsp_tuser: empty_range[0].
   output logic [0:0]   rsp_tuser,

   // Size register write channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [12:0]  csr_data
);

   logic [12:0]         size_ff;
   logic                eng_ready, eng_res_valid, slot_free;
   rmt_pkg::item_type   item;
   rmt_pkg::result_type eng_res;

   logic                rsp_valid_ff;
   logic signed [61:0]  rsp_min_ff;
   logic                rsp_empty_ff;

   // The size register can always take a write.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= rmt_pkg::SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         size_ff <= csr_data;
      end
   end

   // Unpack the request item.
   assign item.req_type    = req_tuser[0];
   assign item.position    = req_tdata[11:0];
   assign item.value       = req_tdata[73:12];
   assign item.range_start = req_tdata[86:74];
   assign item.range_end   = req_tdata[99:87];

   assign req_tready = eng_ready;

   rmt_engine #(.DEPTH(DEPTH), .LEVELS(LEVELS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid && eng_ready),
      .item      (item),
      .size      (size_ff),
      .ready     (eng_ready),
      .res_valid (eng_res_valid),
      .res       (eng_res),
      .res_ready (slot_free)
   );

   // Output register: loads when empty or being drained in this cycle.
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_res_valid && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_res_valid && slot_free) begin
         rsp_min_ff   <= eng_res.minimum;
         rsp_empty_ff <= eng_res.empty_range;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {2'b00, rsp_min_ff};
   assign rsp_tuser[0] = rsp_empty_ff;

endmodule

FILE: bench/tb_radix8_range_min_table.sv
// Self-checking bench for the radix-8 range-minimum table.
//
// A clocked driver feeds request items from a backlog queue that the main
// initial block fills phase by phase. A clocked monitor takes response items
// and compares them with the answers that the bench's own copy of the table
// worked out when each query was accepted. Every phase starts from an idle
// block with a write to the size register, so the whole run walks through
// small, zero, full and oversized settings while the stored levels carry
// over from phase to phase.
module tb_radix8_range_min_table;

   localparam int DEPTH  = 4096;
   localparam int LEVELS = 5;
   localparam int MAX_BOUND = 8191;

   // Adds give no response, so a drained response queue does not prove the
   // engine is done. This many extra cycles covers the longest add, one that
   // updates every upper level, with margin.
   localparam int SETTLE_CYCLES = 60;

   // The reset sweep alone keeps the request channel closed while it clears
   // all LEVELS * DEPTH entries. The limit is several times as long as that sweep.
   localparam int WATCHDOG_LIMIT = 100000;

   localparam logic signed [61:0] MIN_VALUE = {1'b1, 61'd0};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [12:0]  csr_data = '0;

   radix8_range_min_table #(
      .DEPTH  (DEPTH),
      .LEVELS (LEVELS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The bench's own picture of the block: every level of the table and the
   // size setting last written.
   logic signed [61:0] level_store [LEVELS][DEPTH];
   int unsigned        size_setting;

   rmt_pkg::item_type   request_backlog[$];   // items waiting to be driven
   rmt_pkg::result_type awaiting_answers[$];  // answers owed for accepted queries
   rmt_pkg::item_type   on_bus;               // item currently offered on req_*

   // Idle rates in percent of cycles, changed only between phases.
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   int unsigned adds_sent;
   int unsigned queries_sent;
   int unsigned empty_queries;
   int unsigned answers_checked;
   int unsigned mismatches;
   int unsigned quiet_cycles;

   // Positions at or past the depth hold nothing and read as the sentinel.
   function automatic logic signed [61:0] stored_entry(int k, int p);
      if (p >= DEPTH)
         return rmt_pkg::SENTINEL;
      return level_store[k][p];
   endfunction

   // Write level 0, then fold the position into each upper level whose
   // block of 8^k positions still ends inside the size in use. Each upper
   // entry keeps a running minimum of its old value and the children that
   // fit.
   function automatic void fold_add(int pos, logic signed [61:0] val);
      int limit;
      int sub;
      limit = (size_setting > DEPTH) ? DEPTH : int'(size_setting);
      level_store[0][pos] = val;
      for (int k = 1; k < LEVELS && pos + (1 << (3 * k)) <= limit; k++) begin
         sub = 1 << (3 * (k - 1));
         for (int i = 0; i < 8 && pos + (i + 1) * sub <= limit; i++) begin
            if (level_store[k - 1][pos + i * sub] < level_store[k][pos])
               level_store[k][pos] = level_store[k - 1][pos + i * sub];
         end
      end
   endfunction

   // Minimum over [first, stop): the level is the largest one whose block
   // fits in the length, capped at the top level. Blocks are taken at the
   // start and then stepping down from the end while they stay in range.
   function automatic logic signed [61:0] range_min_of(int first, int stop);
      int span;
      int k;
      int blk;
      int p;
      logic signed [61:0] best;
      span = stop - first;
      k = 0;
      while (k + 1 < LEVELS && (1 << (3 * (k + 1))) <= span)
         k++;
      blk = 1 << (3 * k);
      best = stored_entry(k, first);
      p = stop;
      while (p >= first + blk) begin
         p -= blk;
         if (stored_entry(k, p) < best)
            best = stored_entry(k, p);
      end
      return best;
   endfunction

   // Called once for every accepted request item.
   function automatic void predict(rmt_pkg::item_type it);
      rmt_pkg::result_type answer;
      if (it.req_type == rmt_pkg::REQ_ADD) begin
         adds_sent++;
         fold_add(int'(it.position), it.value);
      end else begin
         queries_sent++;
         answer.empty_range = (it.range_start >= it.range_end);
         if (answer.empty_range) begin
            empty_queries++;
            answer.minimum = rmt_pkg::SENTINEL;
         end else begin
            answer.minimum = range_min_of(int'(it.range_start), int'(it.range_end));
         end
         awaiting_answers.push_back(answer);
      end
   endfunction

   // Fields that the request kind does not use carry random bits, so every
   // bit of the item fields toggles and the block must ignore them.
   function automatic void queue_add(int pos, logic signed [61:0] val);
      rmt_pkg::item_type it;
      it.req_type    = rmt_pkg::REQ_ADD;
      it.position    = 12'(pos);
      it.value       = val;
      it.range_start = 13'($urandom);
      it.range_end   = 13'($urandom);
      request_backlog.push_back(it);
   endfunction

   function automatic void queue_query(int first, int stop);
      rmt_pkg::item_type it;
      it.req_type    = rmt_pkg::REQ_QUERY;
      it.position    = 12'($urandom);
      it.value       = 62'({$urandom, $urandom});
      it.range_start = 13'(first);
      it.range_end   = 13'(stop);
      request_backlog.push_back(it);
   endfunction

   // Mostly raw 62-bit patterns and small numbers, now and then the
   // extremes and the sentinel itself.
   function automatic logic signed [61:0] pick_value();
      logic signed [61:0] v;
      case ($urandom_range(0, 15))
         0: v = MIN_VALUE;
         1: v = rmt_pkg::MAX_VALUE;
         2: v = rmt_pkg::SENTINEL;
         3: v = -rmt_pkg::SENTINEL;
         4, 5, 6, 7: begin
            v = 62'($urandom_range(0, 2000));
            v = v - 62'sd1000;
         end
         default: v = 62'({$urandom, $urandom});
      endcase
      return v;
   endfunction

   // The intended use: a run of adds at descending positions, then queries
   // around the run at lengths that pick every level. Half the runs start
   // near position zero so that the upper levels get real content.
   function automatic int queue_burst(int span);
      int top;
      int pos;
      int lowest;
      int n;
      int first;
      int len;
      int queued;
      if ($urandom_range(0, 1) == 0)
         top = $urandom_range(0, span - 1);
      else
         top = $urandom_range(0, (span > 48) ? 47 : span - 1);
      n = $urandom_range(4, 24);
      pos = top;
      lowest = top;
      queued = 0;
      for (int i = 0; i < n && pos >= 0; i++) begin
         queue_add(pos, pick_value());
         lowest = pos;
         pos -= $urandom_range(1, 3);
         queued++;
      end
      for (int q = $urandom_range(2, 6); q > 0; q--) begin
         first = $urandom_range(lowest - ((lowest < 16) ? lowest : 16), top);
         len = $urandom_range(1, 8 << (3 * $urandom_range(0, 4)));
         queue_query(first, (first + len > MAX_BOUND) ? MAX_BOUND : first + len);
         queued++;
      end
      return queued;
   endfunction

   // Anything the fields allow: adds at any position in any order and
   // queries with arbitrary bounds, empty ones included.
   function automatic int queue_noise();
      if ($urandom_range(0, 1) == 0)
         queue_add($urandom_range(0, DEPTH - 1), pick_value());
      else
         queue_query($urandom_range(0, MAX_BOUND), $urandom_range(0, MAX_BOUND));
      return 1;
   endfunction

   function automatic void queue_mix(int count, int span);
      int queued;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(0, 9) < 7)
            queued += queue_burst(span);
         else
            queued += queue_noise();
      end
   endfunction

   // Block until every queued item has gone out and every answer has come
   // back, then let the engine finish any trailing add.
   task automatic wait_drained(input int settle);
      do
         @(negedge clock);
      while (request_backlog.size() != 0 || req_tvalid || awaiting_answers.size() != 0);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_size(input int unsigned size_value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= size_value[12:0];
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      size_setting = size_value;
      @(negedge clock);
   endtask

   // One phase: quiet block, new size, new idle rates, then random items.
   // Halfway the sender holds back until every answer is in, so the block
   // also sees a fully drained pipeline in the middle of traffic.
   task automatic run_phase(input int unsigned size_value, input int unsigned send_pct,
                            input int unsigned recv_pct, input int count);
      int span;
      wait_drained(SETTLE_CYCLES);
      write_size(size_value);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      span = (size_value > DEPTH) ? DEPTH : int'(size_value);
      if (span < 64)
         span = DEPTH;
      queue_mix(count / 2, span);
      wait_drained(0);
      queue_mix(count - count / 2, span);
   endtask

   // Driver: a new item goes on the bus whenever the slot is free, unless
   // the sender idles this cycle. The item leaving the bus is handed to the
   // predictor in the same edge in which it is accepted. During reset the
   // bench's table copy starts out like the cleared block.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         for (int k = 0; k < LEVELS; k++)
            for (int i = 0; i < DEPTH; i++)
               level_store[k][i] = rmt_pkg::SENTINEL;
      end else begin
         if (req_tvalid && req_tready)
            predict(on_bus);
         if (!req_tvalid || req_tready) begin
            if (request_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               on_bus = request_backlog.pop_front();
               req_tdata  <= {4'd0, on_bus.range_end, on_bus.range_start,
                              on_bus.value, on_bus.position};
               req_tuser  <= on_bus.req_type;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: every response item is matched against the oldest answer owed.
   always @(posedge clock) begin : response_check
      rmt_pkg::result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaiting_answers.size() == 0) begin
               $error("response with no query outstanding: minimum %0d empty_range %0b",
                      $signed(rsp_tdata[61:0]), rsp_tuser[0]);
               mismatches++;
            end else begin
               want = awaiting_answers.pop_front();
               answers_checked++;
               if (rsp_tdata[61:0] !== want.minimum) begin
                  $error("minimum: expected %0d, got %0d",
                         $signed(want.minimum), $signed(rsp_tdata[61:0]));
                  mismatches++;
               end
               if (rsp_tuser[0] !== want.empty_range) begin
                  $error("empty_range: expected %0b, got %0b",
                         want.empty_range, rsp_tuser[0]);
                  mismatches++;
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Watchdog: a run with no handshake on any channel for too long is hung.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", quiet_cycles);
         $display("** radix8_range_min_table: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      size_setting    = 32'(rmt_pkg::SIZE_RESET);
      send_idle_pct   = 7;
      recv_idle_pct   = 67;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The size register is taken during the clearing sweep as well.
      write_size(DEPTH);

      // Directed part. On the freshly cleared table: empty ranges in both
      // directions, the widest range, and a range lying wholly past the end
      // of the table, which must read as the sentinel but is not empty.
      queue_query(0, 0);
      queue_query(MAX_BOUND, 0);
      queue_query(0, MAX_BOUND);
      queue_query(DEPTH, MAX_BOUND);
      // Descending adds with the extreme values. The last position only
      // writes level 0; position zero folds into every level.
      queue_add(DEPTH - 1, rmt_pkg::MAX_VALUE);
      queue_add(DEPTH - 2, -62'sd1);
      queue_add(3000, 62'sd123456789);
      queue_add(64, MIN_VALUE);
      queue_add(7, -62'sd5);
      queue_add(1, rmt_pkg::SENTINEL);
      queue_add(0, 62'sd0);
      // Single positions, lengths that pick each level, exact powers of eight,
      // the full table, ranges that run past the table's end, and an empty one.
      queue_query(0, 1);
      queue_query(DEPTH - 1, DEPTH);
      queue_query(DEPTH - 2, DEPTH - 1);
      queue_query(2, 9);
      queue_query(60, 70);
      queue_query(8, 72);
      queue_query(0, 512);
      queue_query(1, DEPTH - 1);
      queue_query(0, DEPTH);
      queue_query(4000, DEPTH);
      queue_query(4088, MAX_BOUND);
      queue_query(100, 99);

      // Random part. The first three phases let the receiver stall most of
      // the time, the next three the sender, the last two run flat out.
      // Sizes cover one position, zero, the full depth, just below it, and
      // values above the depth, which act as the depth.
      run_phase(DEPTH, 7, 67, 160);
      run_phase(1, 7, 67, 150);
      run_phase(MAX_BOUND, 7, 67, 150);
      run_phase(0, 67, 7, 150);
      run_phase($urandom_range(9, DEPTH - 1), 67, 7, 150);
      run_phase(DEPTH - 1, 67, 7, 150);
      run_phase(DEPTH, 0, 0, 180);
      run_phase($urandom_range(DEPTH + 1, MAX_BOUND), 0, 0, 180);

      wait_drained(SETTLE_CYCLES);

      $display("Ran %0d adds and %0d queries (%0d of them empty) across nine size writes,",
               adds_sent, queries_sent, empty_queries);
      $display("with sizes from zero past the depth; %0d responses compared, %0d mismatches.",
               answers_checked, mismatches);
      if (mismatches == 0)
         $display("** radix8_range_min_table: PASSED **");
      else
         $display("** radix8_range_min_table: FAILED **");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/rmt_pkg.sv
hw/rtl/rmt_ram.sv
hw/rtl/rmt_engine.sv
hw/rtl/radix8_range_min_table.sv
bench/tb_radix8_range_min_table.sv
